// ----- rtl/ssf_pkg.sv -----
// shared types, constants and microcode table of the state-space filter
`default_nettype none

package ssf_pkg;

	localparam int MAX_ORDER_DEF = 4;
	localparam int DATA_W = 32;
	localparam int ROW_W = 4;
	localparam int UPC_W = 3;
	localparam int PADDR_W = 3;

	// register select taken from the word address bit
	localparam logic REG_ORDER_IN_USE = 1'b0;

	typedef enum logic [1:0] {
		OP_FILTER = 2'd0,
		OP_WRITE  = 2'd1,
		OP_CLEAR  = 2'd2,
		OP_NONE   = 2'd3
	} ssf_op_t;

	// kind of product term issued by a microcode step
	typedef enum logic [1:0] {
		K_C = 2'd0,
		K_D = 2'd1,
		K_A = 2'd2,
		K_B = 2'd3
	} ssf_kind_t;

	typedef enum logic [1:0] {
		J_NEXT   = 2'd0,
		J_LOOP_J = 2'd1,
		J_LOOP_I = 2'd2,
		J_WAIT   = 2'd3
	} ssf_jmp_t;

	typedef struct packed {
		logic             issue;
		ssf_kind_t        kind;
		ssf_jmp_t         jmp;
		logic [UPC_W-1:0] target;
	} ssf_uword_t;

	// tag that travels with each product term down the mac pipeline
	typedef struct packed {
		logic             valid;
		logic             first;
		logic             last;
		logic             is_y;
		logic [ROW_W-1:0] row;
	} ssf_tag_t;

	// finished dot product after rounding and clipping
	typedef struct packed {
		logic              valid;
		logic              is_y;
		logic [ROW_W-1:0]  row;
		logic [DATA_W-1:0] value;
		logic              clip;
	} ssf_fin_t;

	localparam logic [UPC_W-1:0] UPC_CY  = 3'd0;
	localparam logic [UPC_W-1:0] UPC_DY  = 3'd1;
	localparam logic [UPC_W-1:0] UPC_AX  = 3'd2;
	localparam logic [UPC_W-1:0] UPC_BU  = 3'd3;
	localparam logic [UPC_W-1:0] UPC_END = 3'd4;

	// y = C.x + D.u, then for each row i: x'[i] = A[i].x + B[i].u
	function automatic ssf_uword_t ssf_ucode(input logic [UPC_W-1:0] upc);
		ssf_uword_t w;
		w.issue  = 1'b0;
		w.kind   = K_C;
		w.jmp    = J_WAIT;
		w.target = UPC_END;
		case (upc)
			UPC_CY: begin
				w.issue = 1'b1;
				w.kind  = K_C;
				w.jmp   = J_LOOP_J;
			end
			UPC_DY: begin
				w.issue = 1'b1;
				w.kind  = K_D;
				w.jmp   = J_NEXT;
			end
			UPC_AX: begin
				w.issue = 1'b1;
				w.kind  = K_A;
				w.jmp   = J_LOOP_J;
			end
			UPC_BU: begin
				w.issue  = 1'b1;
				w.kind   = K_B;
				w.jmp    = J_LOOP_I;
				w.target = UPC_AX;
			end
			default: begin
				w.issue = 1'b0;
				w.jmp   = J_WAIT;
			end
		endcase
		return w;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/ssf_if.sv -----
// request and response stream interfaces of the state-space filter
`default_nettype none

interface ssf_req_if
	import ssf_pkg::*;
#(
	parameter int IDX_W = 5
);
	logic              valid;
	logic              ready;
	logic [1:0]        op;
	logic [IDX_W-1:0]  coef_index;
	logic [DATA_W-1:0] coef_value;
	logic [DATA_W-1:0] sample_in;

	modport source (output valid, op, coef_index, coef_value, sample_in, input ready);
	modport sink (input valid, op, coef_index, coef_value, sample_in, output ready);
endinterface

interface ssf_rsp_if
	import ssf_pkg::*;
;
	logic              valid;
	logic              ready;
	logic [DATA_W-1:0] sample_out;
	logic              saturated;

	modport source (output valid, sample_out, saturated, input ready);
	modport sink (input valid, sample_out, saturated, output ready);
endinterface

`default_nettype wire

// ----- rtl/ssf_ram.sv -----
// generic single-write, single-read ram with registered read data
`default_nettype none

module ssf_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 25,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire             clk,
	input  wire             we,
	input  wire  [AW-1:0]   waddr,
	input  wire  [WIDTH-1:0] wdata,
	input  wire  [AW-1:0]   raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// ----- rtl/ssf_mac.sv -----
// multiply-accumulate pipeline with half-up rounding and 32-bit clipping
`default_nettype none

module ssf_mac
	import ssf_pkg::*;
#(
	parameter int MAX_ORDER = MAX_ORDER_DEF
) (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire ssf_tag_t           tag,
	input  wire signed [DATA_W-1:0] coef,
	input  wire signed [DATA_W-1:0] opnd,
	output ssf_fin_t                fin,
	output logic                    busy
);

	// up to MAX_ORDER+1 products of 64 bits plus the rounding half
	localparam int ACC_W = 2 * DATA_W + 1 + $clog2(MAX_ORDER + 1);
	localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(64'h80_0000);

	ssf_tag_t                   tag_s2;
	ssf_tag_t                   tag_s3;
	logic signed [2*DATA_W-1:0] prod_s2;
	logic signed [ACC_W-1:0]    acc_q;
	logic signed [ACC_W-1:0]    rnd;
	logic                       in_range;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s2 <= '0;
			tag_s3 <= '0;
		end else begin
			tag_s2 <= tag;
			tag_s3 <= tag_s2;
		end
	end

	always_ff @(posedge clk) begin
		prod_s2 <= coef * opnd;
		if (tag_s2.valid) begin
			acc_q <= (tag_s2.first ? '0 : acc_q) + ACC_W'(prod_s2);
		end
	end

	// result is rnd[55:24]; it fits when all bits above bit 55 match bit 55
	always_comb begin
		rnd      = acc_q + RND_HALF;
		in_range = (rnd[ACC_W-1:55] == '0) || (rnd[ACC_W-1:55] == '1);
		fin.valid = tag_s3.valid && tag_s3.last;
		fin.is_y  = tag_s3.is_y;
		fin.row   = tag_s3.row;
		fin.clip  = !in_range;
		if (in_range) begin
			fin.value = rnd[55:24];
		end else if (rnd[ACC_W-1]) begin
			fin.value = 32'h8000_0000;
		end else begin
			fin.value = 32'h7fff_ffff;
		end
	end

	assign busy = tag_s2.valid || tag_s3.valid;

endmodule

`default_nettype wire

// ----- rtl/state_space_filter_step.sv -----
// single-input single-output fixed-point state-space filter, microcoded mac sequencer
// a filter beat is served by one shared mac that
// walks every active coefficient, one term per cycle, then the mac pipeline drains;
// input ready returns with the result, so a new filter item is not taken before the last is done
// write, clear and unused items never leave the idle state; a new item is taken while a result waits
// after reset a clearing pass zeroes all DEPTH words of the coefficient ram (25 at the default)
`default_nettype none

module state_space_filter_step
	import ssf_pkg::*;
#(
	parameter int MAX_ORDER = MAX_ORDER_DEF
) (
	input  wire                 clk,
	input  wire                 arst_n,
	ssf_req_if.sink             req,
	ssf_rsp_if.source           rsp,
	input  wire                 psel,
	input  wire                 penable,
	input  wire                 pwrite,
	input  wire  [PADDR_W-1:0]  paddr,
	input  wire  [DATA_W-1:0]   pwdata,
	output logic [DATA_W-1:0]   prdata,
	output logic                pready
);

	localparam int DEPTH   = MAX_ORDER * MAX_ORDER + 2 * MAX_ORDER + 1;
	localparam int AW      = $clog2(DEPTH);
	localparam int RW      = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
	localparam int BD_BASE = MAX_ORDER * MAX_ORDER;
	localparam int CD_BASE = BD_BASE + MAX_ORDER;
	localparam int DD_SLOT = CD_BASE + MAX_ORDER;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_RUN
	} state_t;

	state_t            state_q;
	logic [AW-1:0]     clr_cnt_q;
	logic [UPC_W-1:0]  upc_q;
	logic [RW-1:0]     i_q;
	logic [RW-1:0]     j_q;
	logic [2:0]        order_q;
	logic [DATA_W-1:0] x_q [MAX_ORDER];
	logic [DATA_W-1:0] next_q [MAX_ORDER];
	logic              out_valid_q;
	logic [DATA_W-1:0] out_data_q;
	logic              out_sat_q;
	logic [DATA_W-1:0] u_q;
	logic [DATA_W-1:0] y_q;
	logic              sat_q;
	ssf_tag_t          tag_s1;
	logic [DATA_W-1:0] opnd_s1;

	ssf_uword_t        uw;
	ssf_tag_t          tag_nxt;
	ssf_fin_t          fin;
	logic [RW-1:0]     nm1;
	logic [AW-1:0]     raddr;
	logic [DATA_W-1:0] opnd_nxt;
	logic [DATA_W-1:0] coef;
	logic              mac_busy;
	logic              accept;
	logic              issue;
	logic              pipe_empty;
	logic              commit;
	logic              ram_we;
	logic [AW-1:0]     ram_waddr;
	logic [DATA_W-1:0] ram_wdata;
	logic              cfg_wr;

	// active order minus one, out-of-range settings clamped
	always_comb begin
		if (order_q == 3'd0) begin
			nm1 = '0;
		end else if (int'(order_q) > MAX_ORDER) begin
			nm1 = RW'(MAX_ORDER - 1);
		end else begin
			nm1 = RW'(order_q - 3'd1);
		end
	end

	assign accept     = req.valid && req.ready;
	assign req.ready  = (state_q == ST_IDLE);
	assign uw         = ssf_ucode(upc_q);
	assign issue      = (state_q == ST_RUN) && uw.issue;
	assign pipe_empty = !tag_s1.valid && !mac_busy;
	assign commit     = (state_q == ST_RUN) && (uw.jmp == J_WAIT) && pipe_empty
	                    && (!out_valid_q || rsp.ready);

	// term address, operand and tag for the current microcode step
	always_comb begin
		tag_nxt       = '0;
		tag_nxt.valid = issue;
		tag_nxt.row   = ROW_W'(i_q);
		raddr         = AW'(DD_SLOT);
		opnd_nxt      = u_q;
		case (uw.kind)
			K_C: begin
				raddr         = AW'(CD_BASE) + AW'(j_q);
				opnd_nxt      = x_q[j_q];
				tag_nxt.first = (j_q == '0);
				tag_nxt.is_y  = 1'b1;
			end
			K_D: begin
				raddr        = AW'(DD_SLOT);
				tag_nxt.last = 1'b1;
				tag_nxt.is_y = 1'b1;
			end
			K_A: begin
				raddr         = AW'(i_q) * AW'(MAX_ORDER) + AW'(j_q);
				opnd_nxt      = x_q[j_q];
				tag_nxt.first = (j_q == '0);
			end
			K_B: begin
				raddr        = AW'(BD_BASE) + AW'(i_q);
				tag_nxt.last = 1'b1;
			end
			default: begin
				raddr = AW'(DD_SLOT);
			end
		endcase
	end

	// coefficient ram writes: clearing pass or a write beat
	always_comb begin
		if (state_q == ST_CLEAR) begin
			ram_we    = 1'b1;
			ram_waddr = clr_cnt_q;
			ram_wdata = '0;
		end else begin
			ram_we    = accept && (req.op == OP_WRITE) && (int'(req.coef_index) < DEPTH);
			ram_waddr = AW'(req.coef_index);
			ram_wdata = req.coef_value;
		end
	end

	ssf_ram #(
		.WIDTH (DATA_W),
		.DEPTH (DEPTH)
	) u_coef_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (raddr),
		.rdata (coef)
	);

	ssf_mac #(
		.MAX_ORDER (MAX_ORDER)
	) u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.tag    (tag_s1),
		.coef   (coef),
		.opnd   (opnd_s1),
		.fin    (fin),
		.busy   (mac_busy)
	);

	assign cfg_wr = psel && penable && pwrite && pready;
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_ORDER_IN_USE) ? DATA_W'(order_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_cnt_q   <= '0;
			upc_q       <= UPC_CY;
			i_q         <= '0;
			j_q         <= '0;
			order_q     <= 3'd1;
			out_valid_q <= 1'b0;
			tag_s1      <= '0;
			for (int k = 0; k < MAX_ORDER; k++) begin
				x_q[k] <= '0;
			end
		end else begin
			tag_s1 <= tag_nxt;
			if (cfg_wr && paddr[2] == REG_ORDER_IN_USE) begin
				order_q <= pwdata[2:0];
			end
			if (rsp.valid && rsp.ready && !commit) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_cnt_q <= clr_cnt_q + 1'b1;
					if (clr_cnt_q == AW'(DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept && req.op == OP_FILTER) begin
						state_q <= ST_RUN;
						upc_q   <= UPC_CY;
						i_q     <= '0;
						j_q     <= '0;
					end
					if (accept && req.op == OP_CLEAR) begin
						for (int k = 0; k < MAX_ORDER; k++) begin
							x_q[k] <= '0;
						end
					end
				end
				ST_RUN: begin
					case (uw.jmp)
						J_NEXT: begin
							upc_q <= upc_q + 1'b1;
						end
						J_LOOP_J: begin
							if (j_q == nm1) begin
								j_q   <= '0;
								upc_q <= upc_q + 1'b1;
							end else begin
								j_q <= j_q + 1'b1;
							end
						end
						J_LOOP_I: begin
							j_q <= '0;
							if (i_q == nm1) begin
								i_q   <= '0;
								upc_q <= upc_q + 1'b1;
							end else begin
								i_q   <= i_q + 1'b1;
								upc_q <= uw.target;
							end
						end
						default: begin
							// wait for the drain, then publish y and the new state
							if (commit) begin
								out_valid_q <= 1'b1;
								state_q     <= ST_IDLE;
								for (int k = 0; k < MAX_ORDER; k++) begin
									if (RW'(k) <= nm1) begin
										x_q[k] <= next_q[k];
									end
								end
							end
						end
					endcase
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		opnd_s1 <= opnd_nxt;
		if (accept && req.op == OP_FILTER) begin
			u_q   <= req.sample_in;
			sat_q <= 1'b0;
		end else if (fin.valid) begin
			sat_q <= sat_q | fin.clip;
		end
		if (fin.valid) begin
			if (fin.is_y) begin
				y_q <= fin.value;
			end else begin
				next_q[fin.row[RW-1:0]] <= fin.value;
			end
		end
		if (commit) begin
			out_data_q <= y_q;
			out_sat_q  <= sat_q;
		end
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.sample_out = out_data_q;
	assign rsp.saturated  = out_sat_q;

	a_fin_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		fin.valid |-> state_q == ST_RUN)
		else $error("finished dot product outside a filter run");

	a_rsp_from_commit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp.valid) |-> $past(state_q == ST_RUN))
		else $error("result beat appeared without a filter run");

	a_j_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RUN |-> j_q <= nm1 && i_q <= nm1)
		else $error("row or column counter beyond active order");

	a_no_write_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> state_q != ST_RUN)
		else $error("coefficient write during a filter run");

endmodule

`default_nettype wire
